// ----- design/urb_pkg.sv -----
package urb_pkg;

  // Ring geometry
  parameter int BUF_DEPTH = 64;
  parameter int PTR_W     = $clog2(BUF_DEPTH);
  parameter int CNT_W     = PTR_W + 1;
  parameter int DATA_W    = 8;

  typedef logic [PTR_W-1:0]  ptr_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] data_t;

  // Request action codes
  typedef enum logic [1:0] {
    ACT_GET       = 2'd0,
    ACT_PUT       = 2'd1,
    ACT_RX_ARRIVE = 2'd2,
    ACT_TX_EMPTY  = 2'd3
  } action_t;

  // Response status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DATA = 2'd1,
    ST_FULL    = 2'd2,
    ST_NONE    = 2'd3
  } status_t;

  // Push/pop command into one ring
  typedef struct packed {
    logic  push;
    logic  pop;
    data_t wdata;
  } ring_cmd_t;

  // Occupancy flags of the transmit ring
  typedef struct packed {
    logic empty;
    logic full;
  } ring_stat_t;

  // Pointer advance with wrap at the last entry
  function automatic ptr_t ptr_next(input ptr_t p);
    ptr_t n;
    n = (p == PTR_W'(BUF_DEPTH - 1)) ? '0 : p + 1'b1;
    return n;
  endfunction

endpackage

// ----- design/urb_req_if.sv -----
interface urb_req_if;
  logic              valid;
  logic              ready;
  urb_pkg::action_t  action;
  urb_pkg::data_t    byte_in;
  logic              rx_error;

  modport source (output valid, action, byte_in, rx_error, input ready);
  modport sink   (input valid, action, byte_in, rx_error, output ready);
endinterface

// ----- design/urb_rsp_if.sv -----
interface urb_rsp_if;
  logic              valid;
  logic              ready;
  urb_pkg::status_t  status;
  urb_pkg::data_t    byte_out;
  logic              line_send_valid;
  urb_pkg::data_t    line_send_byte;
  logic              empty_irq_enable;

  modport source (output valid, status, byte_out, line_send_valid, line_send_byte,
                  empty_irq_enable, input ready);
  modport sink   (input valid, status, byte_out, line_send_valid, line_send_byte,
                  empty_irq_enable, output ready);
endinterface

// ----- design/urb_ram.sv -----
module urb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/urb_rx_ring.sv -----
module urb_rx_ring (
  input  logic                clk,
  input  logic                rst,
  input  urb_pkg::ring_cmd_t  cmd,
  output logic                empty,
  output urb_pkg::data_t      rdata
);

  urb_pkg::ptr_t wr_ptr;
  urb_pkg::ptr_t rd_ptr;

  // No full check: the write pointer just wraps over old entries
  assign empty = (wr_ptr == rd_ptr);

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (cmd.push) begin
        wr_ptr <= urb_pkg::ptr_next(wr_ptr);
      end
      if (cmd.pop) begin
        rd_ptr <= urb_pkg::ptr_next(rd_ptr);
      end
    end
  end

  urb_ram #(
    .WIDTH (urb_pkg::DATA_W),
    .DEPTH (urb_pkg::BUF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_ptr),
    .wdata (cmd.wdata),
    .re    (cmd.pop),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

endmodule

// ----- design/urb_tx_ring.sv -----
module urb_tx_ring (
  input  logic                clk,
  input  logic                rst,
  input  urb_pkg::ring_cmd_t  cmd,
  output urb_pkg::ring_stat_t stat,
  output urb_pkg::data_t      rdata
);

  urb_pkg::ptr_t wr_ptr;
  urb_pkg::ptr_t rd_ptr;
  urb_pkg::cnt_t count;

  // Occupancy, modulo the ring depth
  always_comb begin
    if (wr_ptr >= rd_ptr) begin
      count = urb_pkg::CNT_W'(wr_ptr) - urb_pkg::CNT_W'(rd_ptr);
    end else begin
      count = urb_pkg::CNT_W'(wr_ptr) + urb_pkg::CNT_W'(urb_pkg::BUF_DEPTH)
            - urb_pkg::CNT_W'(rd_ptr);
    end
  end

  assign stat.empty = (wr_ptr == rd_ptr);
  assign stat.full  = (count == urb_pkg::CNT_W'(urb_pkg::BUF_DEPTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (cmd.push) begin
        wr_ptr <= urb_pkg::ptr_next(wr_ptr);
      end
      if (cmd.pop) begin
        rd_ptr <= urb_pkg::ptr_next(rd_ptr);
      end
    end
  end

  urb_ram #(
    .WIDTH (urb_pkg::DATA_W),
    .DEPTH (urb_pkg::BUF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (cmd.push),
    .waddr (wr_ptr),
    .wdata (cmd.wdata),
    .re    (cmd.pop),
    .raddr (rd_ptr),
    .rdata (rdata)
  );

endmodule

// ----- design/uart_ring_buffer_pair_unit.sv -----
// The response is registered and is valid in the cycle after its request is taken;
// the response register and each ring RAM's registered read port load at the same edge.
// Throughput: one transaction per cycle; a new request is taken while the
// response is taken, and stalls only while a response waits unread.
// Reset (rst, synchronous): all ring pointers zero, transmitter idle, no response
// pending; ring RAM contents are not cleared.
module uart_ring_buffer_pair_unit (
  input  logic          clk,
  input  logic          rst,
  urb_req_if.sink       req,
  urb_rsp_if.source     rsp
);

  urb_pkg::ring_cmd_t  rx_cmd;
  urb_pkg::ring_cmd_t  tx_cmd;
  logic                rx_empty;
  urb_pkg::ring_stat_t tx_stat;
  urb_pkg::data_t      rx_rdata;
  urb_pkg::data_t      tx_rdata;

  logic                accept;
  logic                tx_busy;
  logic                tx_busy_next;
  urb_pkg::status_t    status_next;
  logic                sel_rx_next;
  logic                send_direct_next;
  logic                send_queued_next;

  logic                rsp_valid;
  urb_pkg::status_t    status_r;
  logic                sel_rx;
  logic                send_direct;
  logic                send_queued;
  urb_pkg::data_t      direct_byte;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;

  // Action decode against current ring state
  always_comb begin
    rx_cmd           = '0;
    tx_cmd           = '0;
    rx_cmd.wdata     = req.byte_in;
    tx_cmd.wdata     = req.byte_in;
    tx_busy_next     = tx_busy;
    status_next      = urb_pkg::ST_NONE;
    sel_rx_next      = 1'b0;
    send_direct_next = 1'b0;
    send_queued_next = 1'b0;
    unique case (req.action)
      urb_pkg::ACT_GET: begin
        if (rx_empty) begin
          status_next = urb_pkg::ST_NO_DATA;
        end else begin
          status_next = urb_pkg::ST_OK;
          rx_cmd.pop  = accept;
          sel_rx_next = 1'b1;
        end
      end
      urb_pkg::ACT_PUT: begin
        if (tx_stat.full) begin
          status_next = urb_pkg::ST_FULL;
        end else begin
          status_next = urb_pkg::ST_OK;
          if (tx_busy) begin
            tx_cmd.push = accept;
          end else begin
            send_direct_next = 1'b1;
            tx_busy_next     = 1'b1;
          end
        end
      end
      urb_pkg::ACT_RX_ARRIVE: begin
        rx_cmd.push = accept && !req.rx_error;
      end
      urb_pkg::ACT_TX_EMPTY: begin
        if (tx_stat.empty) begin
          tx_busy_next = 1'b0;
        end else begin
          tx_cmd.pop       = accept;
          send_queued_next = 1'b1;
        end
      end
      default: begin
        status_next = urb_pkg::ST_NONE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
      tx_busy   <= 1'b0;
    end else begin
      if (accept) begin
        rsp_valid <= 1'b1;
        tx_busy   <= tx_busy_next;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Response payload register
  always_ff @(posedge clk) begin
    if (accept) begin
      status_r    <= status_next;
      sel_rx      <= sel_rx_next;
      send_direct <= send_direct_next;
      send_queued <= send_queued_next;
      direct_byte <= req.byte_in;
    end
  end

  urb_rx_ring u_rx (
    .clk   (clk),
    .rst   (rst),
    .cmd   (rx_cmd),
    .empty (rx_empty),
    .rdata (rx_rdata)
  );

  urb_tx_ring u_tx (
    .clk   (clk),
    .rst   (rst),
    .cmd   (tx_cmd),
    .stat  (tx_stat),
    .rdata (tx_rdata)
  );

  // Response outputs; RAM read data is held until the next transaction
  assign rsp.valid            = rsp_valid;
  assign rsp.status           = status_r;
  assign rsp.byte_out         = sel_rx ? rx_rdata : '0;
  assign rsp.line_send_valid  = send_direct || send_queued;
  assign rsp.line_send_byte   = send_direct ? direct_byte :
                                send_queued ? tx_rdata : '0;
  assign rsp.empty_irq_enable = tx_busy;

  // Checks
  a_send_implies_busy: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.line_send_valid |-> tx_busy)
    else $error("byte sent while transmitter marked idle");

  a_empty_get_no_data: assert property (@(posedge clk) disable iff (rst)
    accept && req.action == urb_pkg::ACT_GET && rx_empty
    |=> rsp.status == urb_pkg::ST_NO_DATA)
    else $error("get on empty receive ring did not report no data");

  a_tx_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(tx_cmd.push && tx_stat.full))
    else $error("push into full transmit ring");

  a_pop_needs_data: assert property (@(posedge clk) disable iff (rst)
    !(tx_cmd.pop && tx_stat.empty) && !(rx_cmd.pop && rx_empty))
    else $error("pop from empty ring");

endmodule

// ----- tb/tb_uart_ring_buffer_pair_unit.sv -----
module tb_uart_ring_buffer_pair_unit;

  localparam int RANDOM_ITEMS = 600;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LONG_HOLD    = 80;
  localparam int HOLD_AT_RSP  = 150;
  localparam int DRAIN_CYCLES = 5;

  // Shapes of the random stimulus
  typedef enum int {
    B_MIXED,
    B_RX_FILL,
    B_RX_DRAIN,
    B_TX_FILL,
    B_TX_DRAIN
  } burst_kind_t;

  typedef struct {
    urb_pkg::status_t status;
    urb_pkg::data_t   byte_out;
    logic             send_valid;
    urb_pkg::data_t   send_byte;
    logic             irq_en;
  } ring_rsp_t;

  // Tracks both rings and the transmitter, and holds the responses still due
  class ring_pair_sb;
    urb_pkg::data_t rx_mem [urb_pkg::BUF_DEPTH];
    urb_pkg::data_t tx_mem [urb_pkg::BUF_DEPTH];
    int             rx_wr, rx_rd, tx_wr, tx_rd;
    logic           busy;
    ring_rsp_t      rsp_due [$];
    int             n_req, n_rsp, n_err;
    int             n_full, n_rx_lost, n_rx_drop, n_no_data, n_direct;

    function new();
      rx_wr = 0; rx_rd = 0; tx_wr = 0; tx_rd = 0;
      busy = 1'b0;
      n_req = 0; n_rsp = 0; n_err = 0;
      n_full = 0; n_rx_lost = 0; n_rx_drop = 0; n_no_data = 0; n_direct = 0;
    endfunction

    // Apply one accepted request and queue the response it causes
    function void note_req(urb_pkg::action_t act, urb_pkg::data_t b, logic err);
      ring_rsp_t r;
      int        tx_used;
      r.status     = urb_pkg::ST_NONE;
      r.byte_out   = '0;
      r.send_valid = 1'b0;
      r.send_byte  = '0;
      case (act)
        urb_pkg::ACT_GET: begin
          if (rx_rd != rx_wr) begin
            r.byte_out = rx_mem[rx_rd];
            rx_rd      = (rx_rd + 1) % urb_pkg::BUF_DEPTH;
            r.status   = urb_pkg::ST_OK;
          end else begin
            r.status = urb_pkg::ST_NO_DATA;
            n_no_data++;
          end
        end
        urb_pkg::ACT_PUT: begin
          tx_used = (tx_wr - tx_rd + urb_pkg::BUF_DEPTH) % urb_pkg::BUF_DEPTH;
          if (tx_used >= urb_pkg::BUF_DEPTH - 1) begin
            r.status = urb_pkg::ST_FULL;
            n_full++;
          end else begin
            if (busy) begin
              tx_mem[tx_wr] = b;
              tx_wr         = (tx_wr + 1) % urb_pkg::BUF_DEPTH;
            end else begin
              // idle transmitter takes the byte directly
              r.send_valid = 1'b1;
              r.send_byte  = b;
              busy         = 1'b1;
              n_direct++;
            end
            r.status = urb_pkg::ST_OK;
          end
        end
        urb_pkg::ACT_RX_ARRIVE: begin
          if (!err) begin
            rx_mem[rx_wr] = b;
            rx_wr         = (rx_wr + 1) % urb_pkg::BUF_DEPTH;
            // write pointer caught up: ring reads as empty, held bytes lost
            if (rx_wr == rx_rd) n_rx_lost++;
          end else begin
            n_rx_drop++;
          end
        end
        default: begin
          if (tx_rd != tx_wr) begin
            r.send_valid = 1'b1;
            r.send_byte  = tx_mem[tx_rd];
            tx_rd        = (tx_rd + 1) % urb_pkg::BUF_DEPTH;
          end else begin
            busy = 1'b0;
          end
        end
      endcase
      r.irq_en = busy;
      rsp_due.push_back(r);
      n_req++;
    endfunction

    // Compare one accepted response with the oldest one due
    function void check_rsp(urb_pkg::status_t st, urb_pkg::data_t bo, logic sv,
                            urb_pkg::data_t sbyte, logic ie);
      ring_rsp_t e;
      n_rsp++;
      if (rsp_due.size() == 0) begin
        $error("response with no request outstanding: status %0d", st);
        n_err++;
        return;
      end
      e = rsp_due.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, got %0d", e.status, st);
        n_err++;
      end
      if (bo !== e.byte_out) begin
        $error("byte_out: expected 0x%02h, got 0x%02h", e.byte_out, bo);
        n_err++;
      end
      if (sv !== e.send_valid) begin
        $error("line_send_valid: expected %0b, got %0b", e.send_valid, sv);
        n_err++;
      end
      if (sbyte !== e.send_byte) begin
        $error("line_send_byte: expected 0x%02h, got 0x%02h", e.send_byte, sbyte);
        n_err++;
      end
      if (ie !== e.irq_en) begin
        $error("empty_irq_enable: expected %0b, got %0b", e.irq_en, ie);
        n_err++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  int   cycle_cnt;
  int   n_directed;
  int   n_random;
  logic req_idle;
  logic rsp_idle;
  logic held_off;

  ring_pair_sb sb;

  urb_req_if req_if ();
  urb_rsp_if rsp_if ();

  uart_ring_buffer_pair_unit i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_if),
    .rsp (rsp_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Offer one request; entered and left at a falling edge
  task automatic send_item(input urb_pkg::action_t act, input urb_pkg::data_t b,
                           input logic err);
    int gap;
    gap = req_idle ? $urandom_range(11, 0) : 0;
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid    <= 1'b1;
    req_if.action   <= act;
    req_if.byte_in  <= b;
    req_if.rx_error <= err;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    sb.note_req(act, b, err);
    @(negedge clk);
  endtask

  // Stop offering until every response due has been taken
  task automatic pause_for_drain();
    req_if.valid <= 1'b0;
    while (sb.rsp_due.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic run_burst(input burst_kind_t kind, input int len);
    urb_pkg::action_t act;
    urb_pkg::data_t   b;
    logic             err;
    logic             noise;
    int               k;
    for (k = 0; k < len; k++) begin
      b     = urb_pkg::data_t'($urandom);
      err   = ($urandom_range(15, 0) == 0);
      noise = ($urandom_range(9, 0) == 0);
      case (kind)
        B_RX_FILL:
          act = noise ? urb_pkg::action_t'($urandom_range(3, 0)) : urb_pkg::ACT_RX_ARRIVE;
        B_RX_DRAIN:
          act = noise ? urb_pkg::action_t'($urandom_range(3, 0)) : urb_pkg::ACT_GET;
        B_TX_FILL:
          act = noise ? urb_pkg::action_t'($urandom_range(3, 0)) : urb_pkg::ACT_PUT;
        B_TX_DRAIN:
          act = noise ? urb_pkg::action_t'($urandom_range(3, 0)) : urb_pkg::ACT_TX_EMPTY;
        default: begin
          act = urb_pkg::action_t'($urandom_range(3, 0));
          err = 1'($urandom_range(1, 0));
        end
      endcase
      send_item(act, b, err);
      n_random++;
    end
  endtask

  // Response side: random stall per transaction, one long hold-off
  initial begin : rsp_side
    int gap;
    rsp_if.ready = 1'b0;
    rsp_idle     = 1'b1;
    held_off     = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      if (sb.n_rsp % 40 == 0) rsp_idle = ($urandom_range(2, 0) != 0);
      gap = rsp_idle ? $urandom_range(11, 0) : 0;
      if (!held_off && sb.n_rsp >= HOLD_AT_RSP) begin
        gap      = LONG_HOLD;
        held_off = 1'b1;
      end
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk); while (rsp_if.valid !== 1'b1);
      sb.check_rsp(rsp_if.status, rsp_if.byte_out, rsp_if.line_send_valid,
                   rsp_if.line_send_byte, rsp_if.empty_irq_enable);
      @(negedge clk);
    end
  end

  // Watchdog
  initial begin : watchdog
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d responses outstanding",
             cycle_cnt, sb.rsp_due.size());
    $display("** uart_ring_buffer_pair_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int burst_no;
    burst_kind_t kind;
    rst             = 1'b1;
    req_if.valid    = 1'b0;
    req_if.action   = urb_pkg::ACT_GET;
    req_if.byte_in  = '0;
    req_if.rx_error = 1'b0;
    req_idle        = 1'b1;
    n_directed      = 0;
    n_random        = 0;
    sb              = new();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty get, idle tx-empty, errored and clean receives, direct and
    // queued sends, draining back to idle
    send_item(urb_pkg::ACT_GET,       8'h00, 1'b0);
    send_item(urb_pkg::ACT_TX_EMPTY,  8'hFF, 1'b1);
    send_item(urb_pkg::ACT_RX_ARRIVE, 8'h00, 1'b0);
    send_item(urb_pkg::ACT_RX_ARRIVE, 8'hFF, 1'b1);
    send_item(urb_pkg::ACT_RX_ARRIVE, 8'hFF, 1'b0);
    send_item(urb_pkg::ACT_GET,       8'hFF, 1'b1);
    send_item(urb_pkg::ACT_GET,       8'h00, 1'b0);
    send_item(urb_pkg::ACT_GET,       8'h00, 1'b0);
    send_item(urb_pkg::ACT_PUT,       8'hFF, 1'b1);
    send_item(urb_pkg::ACT_PUT,       8'h00, 1'b0);
    send_item(urb_pkg::ACT_PUT,       8'hA5, 1'b0);
    send_item(urb_pkg::ACT_TX_EMPTY,  8'h00, 1'b0);
    send_item(urb_pkg::ACT_TX_EMPTY,  8'h5A, 1'b1);
    send_item(urb_pkg::ACT_TX_EMPTY,  8'h00, 1'b0);
    send_item(urb_pkg::ACT_TX_EMPTY,  8'h00, 1'b0);
    send_item(urb_pkg::ACT_PUT,       8'h5A, 1'b1);
    send_item(urb_pkg::ACT_TX_EMPTY,  8'hFF, 1'b0);
    n_directed = sb.n_req;

    // Random bursts; the first four force rx overrun and tx full, then drain
    burst_no = 0;
    while (n_random < RANDOM_ITEMS) begin
      req_idle = ($urandom_range(3, 0) != 0);
      case (burst_no)
        0:       kind = B_RX_FILL;
        1:       kind = B_RX_DRAIN;
        2:       kind = B_TX_FILL;
        3:       kind = B_TX_DRAIN;
        default: kind = burst_kind_t'($urandom_range(4, 0));
      endcase
      if (burst_no < 4) run_burst(kind, 90);
      else              run_burst(kind, $urandom_range(60, 10));
      if (burst_no == 4) pause_for_drain();
      burst_no++;
    end
    req_if.valid <= 1'b0;

    while (sb.rsp_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d transactions (%0d directed), %0d responses, %0d mismatches",
             sb.n_req, n_directed, sb.n_rsp, sb.n_err);
    $display("tx full %0d, rx overruns %0d, errored rx %0d, empty gets %0d, direct sends %0d",
             sb.n_full, sb.n_rx_lost, sb.n_rx_drop, sb.n_no_data, sb.n_direct);
    if (sb.n_err == 0) begin
      $display("** uart_ring_buffer_pair_unit: PASSED **");
    end else begin
      $display("** uart_ring_buffer_pair_unit: FAILED **");
    end
    $finish;
  end

endmodule
